@@ rtl/segment_transform_perspective_project_unit_defines.svh @@
// Assertion macros shared by the segment projection RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef SEGMENT_TRANSFORM_PERSPECTIVE_PROJECT_UNIT_DEFINES_SVH
`define SEGMENT_TRANSFORM_PERSPECTIVE_PROJECT_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define STP_ASSERT_NOW(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define STP_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/stp_pkg.sv @@
// Types, widths and helper functions for the segment projection pipeline.
// No dependencies; imported by the interfaces and every RTL module.
package stp_pkg;

	localparam int COORD_W   = 16;
	localparam int COEF_W    = 16;
	localparam int COEF_FRAC = 12;
	localparam int MAT_N     = 12;
	localparam int MAT_IDX_W = 4;
	localparam int DIM_W     = 12;
	localparam int SCR_W     = 16;
	localparam int COLOR_W   = 8;
	localparam int LANES     = 4;

	localparam int PROD_W = COORD_W + COEF_W;
	localparam int OFS_W  = COEF_W + COEF_FRAC;
	localparam int SUM_W  = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;
	localparam int A_W    = SUM_W + 2;
	localparam int NUM_W  = A_W + DIM_W + 1;
	localparam int DEN_W  = SUM_W + 1;
	localparam int Q_W    = SCR_W;
	localparam int REM_W  = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = Q_W / DIV_STEPS;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
	localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} color_t;

	typedef struct packed {
		logic                      mode;
		logic [MAT_IDX_W-1:0]      coef_index;
		logic signed [COEF_W-1:0]  coef_value;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] start_z;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] end_z;
		logic [COLOR_W-1:0]        color_red;
		logic [COLOR_W-1:0]        color_green;
		logic [COLOR_W-1:0]        color_blue;
	} seg_in_t;

	typedef struct packed {
		logic signed [SCR_W-1:0] start_screen_x;
		logic signed [SCR_W-1:0] start_screen_y;
		logic signed [SCR_W-1:0] end_screen_x;
		logic signed [SCR_W-1:0] end_screen_y;
		logic [COLOR_W-1:0]      line_red;
		logic [COLOR_W-1:0]      line_green;
		logic [COLOR_W-1:0]      line_blue;
		logic                    depth_fault;
	} seg_out_t;

	// Transformed endpoints leaving the matrix stages.
	typedef struct packed {
		logic                             valid;
		logic [1:0][2:0][SUM_W-1:0]       sum;
		color_t                           color;
	} xf_t;

	// One divider lane: remainder, divisor, quotient so far and flags.
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [Q_W-1:0]   quo;
		logic             neg;
		logic             ovf;
	} div_lane_t;

	// Sideband traveling with the divider lanes.
	typedef struct packed {
		logic       valid;
		color_t     color;
		logic [1:0] zf;
	} meta_t;

	function automatic logic signed [COEF_W-1:0] mat_reset_val(input int i);
		if (i == 0 || i == 5 || i == 10)
			return COEF_W'(1 << COEF_FRAC);
		return '0;
	endfunction

endpackage

@@ rtl/stp_if.sv @@
// Valid/ready stream interfaces for segment input and projected output.
// Depends on stp_pkg for the payload types.
interface stp_in_if import stp_pkg::*; ();
	logic    valid;
	logic    ready;
	seg_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface stp_out_if import stp_pkg::*; ();
	logic     valid;
	logic     ready;
	seg_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/stp_xform.sv @@
// Matrix storage and the affine transform stages (products, then row sums).
// Depends on stp_pkg and the assertion macro header.
`include "segment_transform_perspective_project_unit_defines.svh"

module stp_xform import stp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    fire,
	input  seg_in_t data,
	output xf_t     xf
);

	logic signed [COEF_W-1:0]  mat_q [MAT_N];
	logic signed [COORD_W-1:0] pt [2][3];
	logic signed [PROD_W-1:0]  prod_s1 [2][3][3];
	logic signed [OFS_W-1:0]   ofs_s1 [3];
	logic                      valid_s1;
	color_t                    color_s1;
	logic                      load;
	logic                      valid_s2;
	logic [1:0][2:0][SUM_W-1:0] sum_s2;
	color_t                    color_s2;

	assign pt[0][0] = data.start_x;
	assign pt[0][1] = data.start_y;
	assign pt[0][2] = data.start_z;
	assign pt[1][0] = data.end_x;
	assign pt[1][1] = data.end_y;
	assign pt[1][2] = data.end_z;

	assign load = fire && !data.mode && (data.coef_index < MAT_IDX_W'(MAT_N));

	// Load one matrix entry per coefficient beat with an in-range index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAT_N; i++)
				mat_q[i] <= mat_reset_val(i);
		end else if (load) begin
			mat_q[data.coef_index] <= data.coef_value;
		end
	end

	// Stage 1: multiply each coordinate by its coefficient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= fire && data.mode;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 2; e++)
				for (int r = 0; r < 3; r++)
					for (int c = 0; c < 3; c++)
						prod_s1[e][r][c] <= mat_q[r*4+c] * pt[e][c];
			for (int r = 0; r < 3; r++)
				ofs_s1[r] <= OFS_W'(mat_q[r*4+3]) <<< COEF_FRAC;
			color_s1 <= '{red: data.color_red, green: data.color_green,
				blue: data.color_blue};
		end
	end

	// Stage 2: add the row terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 2; e++)
				for (int r = 0; r < 3; r++)
					sum_s2[e][r] <= SUM_W'(ofs_s1[r]) + SUM_W'(prod_s1[e][r][0])
						+ SUM_W'(prod_s1[e][r][1]) + SUM_W'(prod_s1[e][r][2]);
			color_s2 <= color_s1;
		end
	end

	assign xf = '{valid: valid_s2, sum: sum_s2, color: color_s2};

	`STP_ASSERT_NEXT(a_load_entry0, clk, arst_n, load && data.coef_index == '0, mat_q[0] == $past(data.coef_value), "matrix entry 0 not loaded")
	`STP_ASSERT_NEXT(a_load_no_item, clk, arst_n, en && fire && !data.mode, !valid_s1, "coefficient beat entered the pipeline")

endmodule

@@ rtl/stp_div.sv @@
// Pipelined restoring divider, four lanes, DIV_STEPS quotient bits per stage.
// Depends on stp_pkg and the assertion macro header.
`include "segment_transform_perspective_project_unit_defines.svh"

module stp_div import stp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  div_lane_t lane_in [LANES],
	input  meta_t     meta_in,
	output div_lane_t lane_out [LANES],
	output meta_t     meta_out
);

	div_lane_t lane_r [DIV_STAGES][LANES];
	div_lane_t lane_n [DIV_STAGES][LANES];
	meta_t     meta_r [DIV_STAGES];
	div_lane_t lane_src [DIV_STAGES][LANES];
	meta_t     meta_src [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		// Feed each stage from the port or from the stage before it
		if (g == 0) begin : g_head
			assign lane_src[g] = lane_in;
			assign meta_src[g] = meta_in;
		end else begin : g_tail
			assign lane_src[g] = lane_r[g-1];
			assign meta_src[g] = meta_r[g-1];
		end

		// Retire DIV_STEPS quotient bits, most significant first
		always_comb begin : step
			div_lane_t        cur;
			logic [REM_W-1:0] trial;
			for (int l = 0; l < LANES; l++) begin
				cur = lane_src[g][l];
				for (int j = 0; j < DIV_STEPS; j++) begin
					trial = REM_W'(cur.den) << (Q_W - 1 - g*DIV_STEPS - j);
					if (cur.rem >= trial) begin
						cur.rem = cur.rem - trial;
						cur.quo[Q_W-1-g*DIV_STEPS-j] = 1'b1;
					end
				end
				lane_n[g][l] = cur;
			end
		end

		always_ff @(posedge clk) begin
			if (en)
				lane_r[g] <= lane_n[g];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				meta_r[g] <= '0;
			else if (en)
				meta_r[g] <= meta_src[g];
		end
	end

	assign lane_out = lane_r[DIV_STAGES-1];
	assign meta_out = meta_r[DIV_STAGES-1];

	`STP_ASSERT_NOW(a_rem_entry, clk, arst_n, meta_in.valid && !lane_in[0].ovf, lane_in[0].rem < (REM_W'(lane_in[0].den) << Q_W), "divider entered with quotient overflow")
	`STP_ASSERT_NOW(a_rem_exit, clk, arst_n, meta_out.valid && !lane_out[0].ovf, lane_out[0].rem < REM_W'(lane_out[0].den), "divider remainder not reduced")

endmodule

@@ rtl/segment_transform_perspective_project_unit.sv @@
// Segment transform and perspective projection, top level.
// A segment beat passes the transform products and row sums, stages 3 to 5, the divider and the output register.
// Throughput: one beat per cycle while the result beat is not stalled; 8-stage divider, 2 quotient bits a stage.
// In-range coefficient beats take effect for the very next beat; no coefficient beat produces a result.
// Reset (arst_n low, asynchronous) restores the identity matrix, 640x480, empty pipe.
// Depends on stp_pkg, stp_if, stp_xform, stp_div and the assertion macro header.
`include "segment_transform_perspective_project_unit_defines.svh"

module segment_transform_perspective_project_unit import stp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	stp_in_if.sink                seg_in,
	stp_out_if.source             seg_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	cfg_reg_t         reg_sel;

	logic      en;
	logic      fire;
	xf_t       xf;

	logic                    valid_s3;
	logic signed [A_W-1:0]   a_s3 [LANES];
	logic [DEN_W-1:0]        den_s3 [2];
	logic [1:0]              zf_s3;
	color_t                  color_s3;

	logic                    valid_s4;
	logic signed [NUM_W-1:0] num_s4 [LANES];
	logic [DEN_W-1:0]        den_s4 [2];
	logic [1:0]              zf_s4;
	color_t                  color_s4;

	div_lane_t lane_s5 [LANES];
	logic      valid_s5;
	color_t    color_s5;
	logic [1:0] zf_s5;
	meta_t     meta_s5;
	div_lane_t lane_d [LANES];
	meta_t     meta_d;

	logic                    out_valid_q;
	seg_out_t                out_q;
	logic signed [SCR_W-1:0] scr [LANES];

	localparam logic signed [SCR_W-1:0] SCR_MAX = {1'b0, {(SCR_W-1){1'b1}}};
	localparam logic signed [SCR_W-1:0] SCR_MIN = {1'b1, {(SCR_W-1){1'b0}}};

	// Configuration port
	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_WIDTH:  prdata = APB_DATA_W'(width_q);
			REG_HEIGHT: prdata = APB_DATA_W'(height_q);
			default:    prdata = '0;
		endcase
	end

	// Advance the whole pipe unless the result beat is stuck
	assign en           = !out_valid_q || seg_out.ready;
	assign seg_in.ready = en;
	assign fire         = seg_in.valid && en;

	stp_xform u_xform (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.fire   (fire),
		.data   (seg_in.data),
		.xf     (xf)
	);

	// Stage 3: depth magnitude, biased numerators, divisors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (en)
			valid_s3 <= xf.valid;
	end

	always_ff @(posedge clk) begin : s3
		logic signed [A_W-1:0] z;
		logic signed [A_W-1:0] az;
		if (en) begin
			for (int e = 0; e < 2; e++) begin
				z  = A_W'($signed(xf.sum[e][2]));
				az = (z < 0) ? -z : z;
				zf_s3[e]  <= (z == '0);
				den_s3[e] <= {az[SUM_W-1:0], 1'b0};
				for (int k = 0; k < 2; k++)
					a_s3[e*2+k] <= az + (A_W'($signed(xf.sum[e][k])) <<< 1);
			end
			color_s3 <= xf.color;
		end
	end

	// Stage 4: scale by screen size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else if (en)
			valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++)
				num_s4[l] <= a_s3[l] * $signed({1'b0, (l[0] ? height_q : width_q)});
			den_s4   <= den_s3;
			zf_s4    <= zf_s3;
			color_s4 <= color_s3;
		end
	end

	// Stage 5: magnitude, sign and overflow check for the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s5 <= 1'b0;
		else if (en)
			valid_s5 <= valid_s4;
	end

	always_ff @(posedge clk) begin : s5
		logic [NUM_W-1:0] mag;
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				mag = num_s4[l][NUM_W-1] ? NUM_W'(-num_s4[l]) : NUM_W'(num_s4[l]);
				lane_s5[l].rem <= REM_W'(mag);
				lane_s5[l].den <= den_s4[l>>1];
				lane_s5[l].quo <= '0;
				lane_s5[l].neg <= num_s4[l][NUM_W-1];
				lane_s5[l].ovf <= REM_W'(mag) >= (REM_W'(den_s4[l>>1]) << Q_W);
			end
			color_s5 <= color_s4;
			zf_s5    <= zf_s4;
		end
	end

	assign meta_s5 = '{valid: valid_s5, color: color_s5, zf: zf_s5};

	stp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.lane_in  (lane_s5),
		.meta_in  (meta_s5),
		.lane_out (lane_d),
		.meta_out (meta_d)
	);

	// Apply sign, saturate, and zero a faulted endpoint
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (meta_d.zf[l>>1])
				scr[l] = '0;
			else if (!lane_d[l].neg)
				scr[l] = (lane_d[l].ovf || lane_d[l].quo[Q_W-1]) ? SCR_MAX
					: $signed(lane_d[l].quo);
			else
				scr[l] = (lane_d[l].ovf || lane_d[l].quo[Q_W-1]) ? SCR_MIN
					: -$signed(lane_d[l].quo);
		end
	end

	// Output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= meta_d.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.start_screen_x <= scr[0];
			out_q.start_screen_y <= scr[1];
			out_q.end_screen_x   <= scr[2];
			out_q.end_screen_y   <= scr[3];
			out_q.line_red       <= meta_d.color.red;
			out_q.line_green     <= meta_d.color.green;
			out_q.line_blue      <= meta_d.color.blue;
			out_q.depth_fault    <= meta_d.zf[0] | meta_d.zf[1];
		end
	end

	assign seg_out.valid = out_valid_q;
	assign seg_out.data  = out_q;

	`STP_ASSERT_NOW(a_stall_blocks_input, clk, arst_n, out_valid_q && !seg_out.ready, !seg_in.ready, "input taken while result beat stalled")

endmodule

@@ test/tb.sv @@
// Testbench for the segment transform and perspective projection unit.
// Depends on stp_pkg, the stream interfaces in stp_if and the top-level RTL.
// Predicts every projected segment and checks each output beat against it.
module tb;
	import stp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Matrix/viewport shadow with a queue of the segments still to come out
	class seg_scoreboard;
		logic signed [COEF_W-1:0] mat[MAT_N];
		logic [DIM_W-1:0] scr_w, scr_h;
		seg_out_t pending[$];
		int errors, segs_seen, faults_seen;

		function new();
			for (int i = 0; i < MAT_N; i++)
				mat[i] = mat_reset_val(i);
			scr_w = WIDTH_RST;
			scr_h = HEIGHT_RST;
		endfunction

		function longint apply_row(int r, longint x, longint y, longint z);
			return longint'(mat[r*4+3]) * 4096 + longint'(mat[r*4]) * x
				+ longint'(mat[r*4+1]) * y + longint'(mat[r*4+2]) * z;
		endfunction

		function logic [SCR_W-1:0] to_screen(longint c, longint az, logic [DIM_W-1:0] dim);
			longint q;
			q = (longint'(dim) * (az + 2 * c)) / (2 * az);
			if (q > 32767) q = 32767;
			if (q < -32768) q = -32768;
			return q[SCR_W-1:0];
		endfunction

		// Project one endpoint; returns 1 on zero depth
		function bit endpoint(longint x, longint y, longint z,
				output logic [SCR_W-1:0] sx, output logic [SCR_W-1:0] sy);
			longint tx, ty, tz;
			tx = apply_row(0, x, y, z);
			ty = apply_row(1, x, y, z);
			tz = apply_row(2, x, y, z);
			if (tz == 0) begin
				sx = '0;
				sy = '0;
				return 1'b1;
			end
			if (tz < 0) tz = -tz;
			sx = to_screen(tx, tz, scr_w);
			sy = to_screen(ty, tz, scr_h);
			return 1'b0;
		endfunction

		// Note an accepted input beat
		function void note(seg_in_t d);
			seg_out_t e;
			bit f0, f1;
			if (d.mode == 1'b0) begin
				if (d.coef_index < MAT_N)
					mat[d.coef_index] = d.coef_value;
				return;
			end
			f0 = endpoint(d.start_x, d.start_y, d.start_z, e.start_screen_x, e.start_screen_y);
			f1 = endpoint(d.end_x, d.end_y, d.end_z, e.end_screen_x, e.end_screen_y);
			e.line_red = d.color_red;
			e.line_green = d.color_green;
			e.line_blue = d.color_blue;
			e.depth_fault = f0 | f1;
			pending.insert(pending.size(), e);
		endfunction

		function void report(string what, longint got, longint want);
			$display("tb: mismatch %s got %0d want %0d", what, got, want);
			errors++;
		endfunction

		// Compare one output beat with the oldest expectation
		function void check(seg_out_t g);
			seg_out_t e;
			if (pending.size() == 0) begin
				report("unexpected beat", 1, 0);
				return;
			end
			e = pending.pop_front();
			segs_seen++;
			if (e.depth_fault) faults_seen++;
			if (g.start_screen_x !== e.start_screen_x)
				report("start_screen_x", g.start_screen_x, e.start_screen_x);
			if (g.start_screen_y !== e.start_screen_y)
				report("start_screen_y", g.start_screen_y, e.start_screen_y);
			if (g.end_screen_x !== e.end_screen_x)
				report("end_screen_x", g.end_screen_x, e.end_screen_x);
			if (g.end_screen_y !== e.end_screen_y)
				report("end_screen_y", g.end_screen_y, e.end_screen_y);
			if (g.line_red !== e.line_red) report("line_red", g.line_red, e.line_red);
			if (g.line_green !== e.line_green)
				report("line_green", g.line_green, e.line_green);
			if (g.line_blue !== e.line_blue) report("line_blue", g.line_blue, e.line_blue);
			if (g.depth_fault !== e.depth_fault)
				report("depth_fault", g.depth_fault, e.depth_fault);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	stp_in_if seg_in();
	stp_out_if seg_out();

	segment_transform_perspective_project_unit u_dut (
		.clk(clk), .arst_n(arst_n), .seg_in(seg_in), .seg_out(seg_out),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	seg_scoreboard sb = new();
	bit calm = 1'b0;
	bit hold_out = 1'b0;
	int beats_in = 0;

	always #1 clk = ~clk;

	initial begin
		seg_in.valid = 1'b0;
		seg_in.data = '0;
		seg_out.ready = 1'b0;
	end

	// Output side: random stalls, none while calm, stalled throughout while held off
	always @(negedge clk) begin
		if (hold_out)
			seg_out.ready <= 1'b0;
		else
			seg_out.ready <= calm || ($urandom_range(99) >= 20);
	end

	always @(posedge clk) begin
		if (arst_n && seg_out.valid && seg_out.ready)
			sb.check(seg_out.data);
	end

	// Offer one beat, with random gaps, and hold it until accepted
	task automatic send_beat(seg_in_t d);
		while (!calm && $urandom_range(99) < 20) begin
			seg_in.valid <= 1'b0;
			@(negedge clk);
		end
		seg_in.valid <= 1'b1;
		seg_in.data <= d;
		do @(posedge clk); while (!seg_in.ready);
		sb.note(d);
		beats_in++;
		@(negedge clk);
	endtask

	task automatic drain();
		seg_in.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Write a viewport register, then read it back
	task automatic cfg_write(cfg_reg_t r, logic [DIM_W-1:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(4 * int'(r)); pwdata <= 32'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0; penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[DIM_W-1:0] !== v)
			sb.report("readback", prdata, v);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
		if (r == REG_WIDTH) sb.scr_w = v;
		else sb.scr_h = v;
		@(negedge clk);
	endtask

	function automatic seg_in_t load_item(int idx, logic [15:0] v);
		seg_in_t d;
		d = '0;
		d.mode = 1'b0;
		d.coef_index = idx[MAT_IDX_W-1:0];
		d.coef_value = v;
		d.start_x = 16'($urandom);
		d.end_z = 16'($urandom);
		d.color_blue = 8'($urandom);
		return d;
	endfunction

	function automatic seg_in_t seg_item(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
			logic [15:0] ex, logic [15:0] ey, logic [15:0] ez);
		seg_in_t d;
		d.mode = 1'b1;
		d.coef_index = MAT_IDX_W'($urandom);
		d.coef_value = 16'($urandom);
		d.start_x = sx; d.start_y = sy; d.start_z = sz;
		d.end_x = ex; d.end_y = ey; d.end_z = ez;
		d.color_red = 8'($urandom); d.color_green = 8'($urandom);
		d.color_blue = 8'($urandom);
		return d;
	endfunction

	function automatic logic [15:0] coord_val();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(2048)) - 1024);
			2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
			default: return 16'($signed($urandom_range(512)) - 256);
		endcase
	endfunction

	function automatic seg_in_t rand_seg();
		logic [15:0] sz, ez;
		sz = ($urandom_range(9) == 0) ? 16'h0 : coord_val();
		ez = ($urandom_range(9) == 0) ? 16'h0 : coord_val();
		return seg_item(coord_val(), coord_val(), sz, coord_val(), coord_val(), ez);
	endfunction

	// Full matrix load with plausible content, then a burst of segments
	task automatic send_group();
		logic [15:0] v;
		bit plain_z;
		plain_z = $urandom_range(99) < 40;
		for (int i = 0; i < MAT_N; i++) begin
			if (i >= 8 && plain_z)
				v = (i == 10) ? 16'd4096 : 16'd0;
			else if (i % 4 == 3)
				v = $urandom_range(1) ? coord_val() : 16'($signed($urandom_range(4096)) - 2048);
			else if ($urandom_range(9) == 0)
				v = 16'($urandom);
			else
				v = 16'($signed($urandom_range(16384)) - 8192);
			send_beat(load_item(i, v));
		end
		repeat ($urandom_range(12, 2)) send_beat(rand_seg());
	endtask

	task automatic send_noise();
		if ($urandom_range(1))
			send_beat(load_item(int'($urandom_range(15)), 16'($urandom)));
		else
			send_beat(rand_seg());
	endtask

	task automatic directed();
		send_beat(seg_item(16'h0100, 16'h0100, 16'h0100, 16'hff00, 16'hff00, 16'h0100));
		send_beat(seg_item(16'h7fff, 16'h8000, 16'h0001, 16'h8000, 16'h7fff, 16'h8000));
		// zero depth at the start, then at the end
		send_beat(seg_item(16'h1234, 16'h4321, 16'h0000, 16'h0010, 16'h0020, 16'h0100));
		send_beat(seg_item(16'h0010, 16'h0020, 16'hff00, 16'h7fff, 16'h8000, 16'h0000));
		send_beat(seg_item(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		// out-of-range indices are dropped
		for (int i = 12; i < 16; i++)
			send_beat(load_item(i, 16'h7fff));
		send_beat(seg_item(16'h0200, 16'hfe00, 16'h0080, 16'h0001, 16'hffff, 16'hffff));
		send_beat(load_item(0, 16'h7fff));
		send_beat(load_item(3, 16'h8000));
		send_beat(load_item(7, 16'h7fff));
		send_beat(load_item(11, 16'h8000));
		send_beat(seg_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000));
		send_beat(load_item(11, 16'h0000));
		send_beat(load_item(8, 16'h8000));
		send_beat(seg_item(16'h8000, 16'h0000, 16'h8000, 16'h0001, 16'h0000, 16'h0000));
		// back to identity
		send_beat(load_item(0, 16'd4096));
		send_beat(load_item(3, 16'd0));
		send_beat(load_item(7, 16'd0));
		send_beat(load_item(8, 16'd0));
		send_beat(seg_item(16'hffff, 16'h0001, 16'hffff, 16'h0fff, 16'hf001, 16'h0003));
	endtask

	// Hold off the output for a long stretch while input keeps coming
	task automatic hold_outputs();
		hold_out = 1'b1;
		repeat (300) @(negedge clk);
		hold_out = 1'b0;
	endtask

	initial begin
		logic [DIM_W-1:0] wv[5], hv[5];
		int target;
		wv = '{12'd640, 12'd4095, 12'd1, 12'd0, 12'd0};
		hv = '{12'd480, 12'd4095, 12'd1, 12'd0, 12'd0};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		directed();
		drain();
		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 3) begin
				wv[3] = 12'd0; hv[3] = DIM_W'($urandom_range(4095));
			end
			if (ph == 4) begin
				wv[4] = DIM_W'($urandom_range(4095, 1));
				hv[4] = DIM_W'($urandom_range(4095, 1));
			end
			cfg_write(REG_WIDTH, wv[ph]);
			cfg_write(REG_HEIGHT, hv[ph]);
			calm = (ph == 2);
			target = beats_in + 270;
			if (ph == 1)
				fork
					hold_outputs();
				join_none
			while (beats_in < target) begin
				if ($urandom_range(99) < 75) send_group();
				else send_noise();
			end
			// Pause input until every segment is out
			drain();
		end
		calm = 1'b0;
		repeat (40) @(negedge clk);
		$display("tb: %0d beats in, %0d segments checked, %0d with depth fault, 5 viewports",
			beats_in, sb.segs_seen, sb.faults_seen);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: timeout");
		$display("tb: done, errors");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/stp_pkg.sv
rtl/stp_if.sv
rtl/stp_xform.sv
rtl/stp_div.sv
rtl/segment_transform_perspective_project_unit.sv
test/tb.sv
